// File: hw/rtl/jcs_pkg.sv
// Package with the types, constants and command tables of the command sequencer.
`timescale 1ns / 1ps

package jcs_pkg;

  localparam logic [15:0] RESET_WINDOW = 16'd5000;

  localparam logic [1:0] CMD_RESET = 2'd0;
  localparam logic [1:0] CMD_INIT  = 2'd1;
  localparam logic [1:0] CMD_POLL  = 2'd2;

  localparam logic [4:0] SHORT_CMD_LEN = 5'd8;
  localparam logic [4:0] POLL_CMD_LEN  = 5'd24;

  localparam logic [2:0] DATA_BIT_TICKS = 3'd5;
  localparam logic [2:0] STOP_BIT_TICKS = 3'd4;

  typedef struct packed {
    logic        transmitting;
    logic [1:0]  command_select;
    logic        in_stop_bit;
    logic [15:0] bit_or_sample_count;
    logic [2:0]  tick_in_bit;
  } seq_state_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       sample_valid;
    logic       sample_level;
    logic [1:0] command_id;
  } seq_result_t;

  localparam seq_state_t STATE_RESET = '{
    transmitting:        1'b1,
    command_select:      CMD_RESET,
    in_stop_bit:         1'b0,
    bit_or_sample_count: 16'd0,
    tick_in_bit:         3'd0
  };

  function automatic logic [23:0] cmd_pattern(input logic [1:0] c);
    case (c)
      CMD_INIT: cmd_pattern = 24'h000000;
      CMD_POLL: cmd_pattern = 24'h400300;
      default:  cmd_pattern = 24'h0000FF;
    endcase
  endfunction

  function automatic logic [4:0] cmd_length(input logic [1:0] c);
    cmd_length = (c == CMD_POLL) ? POLL_CMD_LEN : SHORT_CMD_LEN;
  endfunction

  function automatic logic [1:0] cmd_next(input logic [1:0] c);
    case (c)
      CMD_INIT: cmd_next = CMD_POLL;
      CMD_POLL: cmd_next = CMD_RESET;
      default:  cmd_next = CMD_INIT;
    endcase
  endfunction

endpackage

// File: hw/rtl/jcs_step.sv
// Next-state and result logic for one tick of the command sequencer.
`timescale 1ns / 1ps

module jcs_step (
  input  jcs_pkg::seq_state_t  state_cur,
  input  logic                 line_level,
  input  logic [15:0]          receive_window,
  output jcs_pkg::seq_state_t  state_nxt,
  output jcs_pkg::seq_result_t result
);
  import jcs_pkg::*;

  logic [4:0]  len;
  logic [15:0] idx;
  logic [4:0]  pos;
  logic [2:0]  t_data;
  logic [2:0]  t_stop;
  logic [2:0]  tick_inc;
  logic [23:0] pattern_shifted;
  logic        data_bit;
  logic [15:0] count_tmp;

  always_comb begin
    len             = cmd_length(state_cur.command_select);
    idx             = (state_cur.bit_or_sample_count >= {11'd0, len}) ?
                      {11'd0, len - 5'd1} : state_cur.bit_or_sample_count;
    pos             = len - 5'd1 - idx[4:0];
    pattern_shifted = cmd_pattern(state_cur.command_select) >> pos;
    data_bit        = pattern_shifted[0];
    t_data          = (state_cur.tick_in_bit < DATA_BIT_TICKS) ?
                      state_cur.tick_in_bit : DATA_BIT_TICKS - 3'd1;
    t_stop          = (state_cur.tick_in_bit < STOP_BIT_TICKS) ?
                      state_cur.tick_in_bit : STOP_BIT_TICKS - 3'd1;
    tick_inc        = 3'd0;
    count_tmp       = state_cur.bit_or_sample_count;

    state_nxt           = state_cur;
    result.drive_enable = 1'b0;
    result.drive_level  = 1'b0;
    result.sample_valid = 1'b0;
    result.sample_level = 1'b0;
    result.command_id   = state_cur.command_select;

    if (state_cur.transmitting) begin
      result.drive_enable = 1'b1;
      if (!state_cur.in_stop_bit) begin
        result.drive_level = data_bit ? (t_data != 3'd0) :
                             (t_data == DATA_BIT_TICKS - 3'd1);
        tick_inc = t_data + 3'd1;
        state_nxt.tick_in_bit = tick_inc;
        if (tick_inc >= DATA_BIT_TICKS) begin
          state_nxt.tick_in_bit = 3'd0;
          count_tmp = idx + 16'd1;
        end
        state_nxt.bit_or_sample_count = count_tmp;
        if (count_tmp >= {11'd0, len}) begin
          state_nxt.tick_in_bit         = 3'd0;
          state_nxt.bit_or_sample_count = 16'd0;
          state_nxt.in_stop_bit         = 1'b1;
        end
      end else begin
        result.drive_level = (t_stop != 3'd0);
        tick_inc = t_stop + 3'd1;
        state_nxt.tick_in_bit = tick_inc;
        if (tick_inc >= STOP_BIT_TICKS) begin
          state_nxt.transmitting        = 1'b0;
          state_nxt.bit_or_sample_count = 16'd0;
          state_nxt.tick_in_bit         = 3'd0;
          state_nxt.in_stop_bit         = 1'b0;
          state_nxt.command_select      = cmd_next(state_cur.command_select);
        end
      end
    end else begin
      if (state_cur.bit_or_sample_count < receive_window) begin
        result.sample_valid           = 1'b1;
        result.sample_level           = line_level;
        state_nxt.bit_or_sample_count = state_cur.bit_or_sample_count + 16'd1;
      end else begin
        state_nxt.transmitting        = 1'b1;
        state_nxt.bit_or_sample_count = 16'd0;
        state_nxt.tick_in_bit         = 3'd0;
      end
    end
  end

endmodule

// File: hw/rtl/joybus_command_sequencer_top.sv
// Top level of the single-wire controller command sequencer.
`timescale 1ns / 1ps

// Channel     | Ports                                   | Direction
// ------------+-----------------------------------------+----------
// tick in     | in_valid, in_ready, in_line_level       | input
// result out  | out_valid, out_ready, out_drive_enable, | output
//             | out_drive_level, out_sample_valid,      |
//             | out_sample_level, out_command_id        |
// config      | cfg_valid, cfg_ready, cfg_receive_window| input
//
// Each item passes an input register and then the result register, and its result is
// offered from there; one item is taken per cycle while the result is not stalled.
// The sequencer state advances when an item moves from the input register into the
// result register. A stalled result register holds the input register, which then
// holds off in_ready. Reset is synchronous and puts the block at the reset command.

module joybus_command_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_line_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_drive_enable,
  output logic        out_drive_level,
  output logic        out_sample_valid,
  output logic        out_sample_level,
  output logic [1:0]  out_command_id,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_receive_window
);
  import jcs_pkg::*;

  logic        s1_valid_r;
  logic        s1_level_r;
  logic        out_valid_r;
  seq_result_t result_r;
  seq_state_t  state_r;
  seq_state_t  state_nxt;
  seq_result_t result_nxt;
  logic [15:0] window_r;
  logic        advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  jcs_step u_step (
    .state_cur      (state_r),
    .line_level     (s1_level_r),
    .receive_window (window_r),
    .state_nxt      (state_nxt),
    .result         (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
      window_r    <= RESET_WINDOW;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        window_r <= cfg_receive_window;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_level_r <= in_line_level;
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive_enable = result_r.drive_enable;
  assign out_drive_level  = result_r.drive_level;
  assign out_sample_valid = result_r.sample_valid;
  assign out_sample_level = result_r.sample_level;
  assign out_command_id   = result_r.command_id;

endmodule
